@@ sv/tae_pkg.sv @@
// Shared constants, register map and helpers for the temperature alarm escalation core.
package tae_pkg;

	localparam int IN_W  = 24;
	localparam int OUT_W = 72;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam int TEMP_W = 25;
	localparam int AGE_W = 8;
	localparam int MS_W = 9;
	localparam int DEG_W = 7;

	// Register indexes, taken from paddr[4:2].
	localparam logic [2:0] REG_RAISE_LIMIT  = 3'd0;
	localparam logic [2:0] REG_LOWER_LIMIT  = 3'd1;
	localparam logic [2:0] REG_START_PRESET = 3'd2;
	localparam logic [2:0] REG_FIRST_STAGE  = 3'd3;
	localparam logic [2:0] REG_SECOND_STAGE = 3'd4;

	localparam logic [DEG_W-1:0] RAISE_LIMIT_RST  = 7'd36;
	localparam logic [DEG_W-1:0] LOWER_LIMIT_RST  = 7'd18;
	localparam logic [DEG_W-1:0] START_PRESET_RST = 7'd28;
	localparam logic [AGE_W-1:0] FIRST_STAGE_RST  = 8'd60;
	localparam logic [AGE_W-1:0] SECOND_STAGE_RST = 8'd120;

	localparam logic [11:0] ADC_SCALE = 12'd3300;
	localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 25'sd2048000;
	localparam logic signed [TEMP_W-1:0] DEG_UNITS = 25'sd40960;

	localparam logic [MS_W-1:0] LONG_PERIOD_MS  = 9'd500;
	localparam logic [MS_W-1:0] SHORT_PERIOD_MS = 9'd100;
	localparam logic [MS_W-1:0] FULL_PULSE_MS   = 9'd500;
	localparam logic [MS_W-1:0] ALARM_PULSE_MS  = 9'd100;
	localparam logic [MS_W-1:0] SHORT_PULSE_MS  = 9'd20;
	localparam logic [AGE_W-1:0] AGE_MAX = 8'd255;

	typedef struct packed {
		logic [AGE_W-1:0] seconds_passed;
		logic             restart_button_n;
		logic             down_button_n;
		logic             up_button_n;
		logic [11:0]      adc_code;
	} in_item_t;

	typedef struct packed {
		logic [1:0]              pad;
		logic                    relay_closed;
		logic [MS_W-1:0]         pwm_pulse_ms;
		logic [MS_W-1:0]         pwm_period_ms;
		logic                    alarm_active;
		logic signed [TEMP_W-1:0] preset_q;
		logic signed [TEMP_W-1:0] temperature_q;
	} out_item_t;

	// Whole degrees to 1/40960 degC: d * 40960 = (d << 13) + (d << 15).
	function automatic logic signed [TEMP_W-1:0] deg_to_units(input logic [DEG_W-1:0] d);
		logic [22:0] sum;
		sum = 23'({d, 13'b0}) + 23'({d, 15'b0});
		return $signed({2'b00, sum});
	endfunction

endpackage

@@ sv/temperature_alarm_escalation_core.sv @@
// Temperature alarm escalation core: sample conversion, preset control and alarm staging.
//
//  Channel  Direction  Contents
//  s_*      in         one sample period request: ADC code, buttons, elapsed seconds
//  m_*      out        one result per request: temperatures, alarm, PWM, relay
//  APB      in/out     five configuration registers at byte addresses 0x00..0x10
//
// One request per clock while the output is not stalled. The ADC code is scaled into
// the input register; the state update and result are formed from it and registered in
// the output register. The output register lets a new request enter while a result
// waits. Reset loads the register defaults and the start preset; no clearing pass.
module temperature_alarm_escalation_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// adc_code[11:0], up_button_n[12], down_button_n[13], restart_button_n[14],
	// seconds_passed[22:15], zero[23]
	input  logic [tae_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// temperature_q[24:0], preset_q[49:25], alarm_active[50], pwm_period_ms[59:51],
	// pwm_pulse_ms[68:60], relay_closed[69], zero[71:70]
	output logic [tae_pkg::OUT_W-1:0]   m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tae_pkg::ADDR_W-1:0]  paddr,
	input  logic [tae_pkg::DATA_W-1:0]  pwdata,
	output logic [tae_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import tae_pkg::*;

	in_item_t in_item;
	logic [2:0] reg_idx;
	logic cfg_wr;

	logic [DEG_W-1:0] raise_limit_q, lower_limit_q, start_preset_q;
	logic [AGE_W-1:0] first_stage_q, second_stage_q;

	logic signed [TEMP_W-1:0] preset_q;
	logic alarm_q, short_q, relay_q;
	logic [AGE_W-1:0] age_q;
	logic [MS_W-1:0] pulse_q;

	logic valid_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	logic up_s1, down_s1, restart_s1;
	logic [AGE_W-1:0] secs_s1;

	logic [23:0] adc_prod;
	logic signed [TEMP_W-1:0] temp_in;
	logic advance;

	logic signed [TEMP_W-1:0] nx_preset;
	logic nx_alarm, nx_short, nx_relay;
	logic [AGE_W-1:0] nx_age;
	logic [MS_W-1:0] nx_pulse;
	logic [AGE_W:0] age_sum;
	out_item_t res;

	assign in_item = in_item_t'(s_tdata[IN_W-2:0]);
	assign adc_prod = 24'(in_item.adc_code) * 24'(ADC_SCALE);
	assign temp_in = $signed({1'b0, adc_prod}) - TEMP_OFFSET;

	assign advance = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Configuration port
	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_idx)
			REG_RAISE_LIMIT:  prdata = DATA_W'(raise_limit_q);
			REG_LOWER_LIMIT:  prdata = DATA_W'(lower_limit_q);
			REG_START_PRESET: prdata = DATA_W'(start_preset_q);
			REG_FIRST_STAGE:  prdata = DATA_W'(first_stage_q);
			REG_SECOND_STAGE: prdata = DATA_W'(second_stage_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raise_limit_q  <= RAISE_LIMIT_RST;
			lower_limit_q  <= LOWER_LIMIT_RST;
			start_preset_q <= START_PRESET_RST;
			first_stage_q  <= FIRST_STAGE_RST;
			second_stage_q <= SECOND_STAGE_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_RAISE_LIMIT:  raise_limit_q  <= pwdata[DEG_W-1:0];
				REG_LOWER_LIMIT:  lower_limit_q  <= pwdata[DEG_W-1:0];
				REG_START_PRESET: start_preset_q <= pwdata[DEG_W-1:0];
				REG_FIRST_STAGE:  first_stage_q  <= pwdata[AGE_W-1:0];
				REG_SECOND_STAGE: second_stage_q <= pwdata[AGE_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			temp_s1    <= temp_in;
			up_s1      <= !in_item.up_button_n;
			down_s1    <= !in_item.down_button_n;
			restart_s1 <= !in_item.restart_button_n;
			secs_s1    <= in_item.seconds_passed;
		end
	end

	// Per-request state update.
	always_comb begin
		nx_preset = preset_q;
		nx_alarm  = alarm_q;
		nx_short  = short_q;
		nx_relay  = relay_q;
		nx_pulse  = pulse_q;
		nx_age    = age_q;

		age_sum = {1'b0, age_q} + {1'b0, secs_s1};
		if (alarm_q) begin
			nx_age = age_sum[AGE_W] ? AGE_MAX : age_sum[AGE_W-1:0];
		end

		if (up_s1 && nx_preset <= deg_to_units(raise_limit_q)) begin
			nx_preset = nx_preset + DEG_UNITS;
		end
		if (down_s1 && nx_preset >= deg_to_units(lower_limit_q)) begin
			nx_preset = nx_preset - DEG_UNITS;
		end

		if (restart_s1) begin
			nx_alarm  = 1'b0;
			nx_age    = '0;
			nx_short  = 1'b0;
			nx_pulse  = FULL_PULSE_MS;
			nx_relay  = 1'b1;
			nx_preset = temp_s1;
		end

		if (!nx_alarm && temp_s1 > nx_preset) begin
			nx_alarm = 1'b1;
			nx_age   = '0;
			nx_pulse = ALARM_PULSE_MS;
		end

		// An age that jumps past both stages only opens the relay.
		if (nx_alarm) begin
			if (nx_age >= first_stage_q && nx_age < second_stage_q) begin
				nx_short = 1'b1;
				nx_pulse = SHORT_PULSE_MS;
			end else if (nx_age >= second_stage_q) begin
				nx_relay = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_q <= deg_to_units(START_PRESET_RST);
			alarm_q  <= 1'b0;
			age_q    <= '0;
			short_q  <= 1'b0;
			pulse_q  <= FULL_PULSE_MS;
			relay_q  <= 1'b1;
		end else if (cfg_wr && reg_idx == REG_START_PRESET) begin
			preset_q <= deg_to_units(pwdata[DEG_W-1:0]);
		end else if (advance) begin
			preset_q <= nx_preset;
			alarm_q  <= nx_alarm;
			age_q    <= nx_age;
			short_q  <= nx_short;
			pulse_q  <= nx_pulse;
			relay_q  <= nx_relay;
		end
	end

	always_comb begin
		res.pad           = '0;
		res.relay_closed  = nx_relay;
		res.pwm_pulse_ms  = nx_pulse;
		res.pwm_period_ms = nx_short ? SHORT_PERIOD_MS : LONG_PERIOD_MS;
		res.alarm_active  = nx_alarm;
		res.preset_q      = nx_preset;
		res.temperature_q = temp_s1;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= OUT_W'(res);
		end
	end

	// The relay opens only under a latched alarm.
	assert property (@(posedge clk) disable iff (!arst_n) !relay_q |-> alarm_q)
		else $error("relay open without a latched alarm");

	// Short period mode and the 20 ms pulse always go together.
	assert property (@(posedge clk) disable iff (!arst_n)
		short_q |-> (alarm_q && pulse_q == SHORT_PULSE_MS))
		else $error("short mode without alarm or short pulse");

	// Without an alarm the age is zero and the buzzer pulse is full.
	assert property (@(posedge clk) disable iff (!arst_n)
		!alarm_q |-> (age_q == '0 && pulse_q == FULL_PULSE_MS && !short_q))
		else $error("idle alarm state is not clean");

	// A stalled result stays valid and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result overwritten under stall");

endmodule
